// ===== hw/rtl/cau_pkg.sv =====
// Shared types, constants and saturation helpers for the complex arithmetic unit.
`timescale 1ns / 1ps

package cau_pkg;

	localparam int FRAC_BITS_DEF = 16;
	// One cell per quotient / root bit.
	localparam int NCELLS = 32;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_NEG  = 3'd4,
		OP_CONJ = 3'd5,
		OP_MAG  = 3'd6,
		OP_EQ   = 3'd7
	} cau_op_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] a_real;
		logic signed [31:0] a_imag;
		logic signed [31:0] b_real;
		logic signed [31:0] b_imag;
	} cau_req_t;

	typedef struct packed {
		logic signed [31:0] res_real;
		logic signed [31:0] res_imag;
		logic               flag;
		logic               overflow;
	} cau_rsp_t;

	// Arithmetic state handed from cell to cell.
	typedef struct packed {
		logic [63:0] den;      // divisor, also the radicand
		logic [63:0] rem_re;
		logic [63:0] rem_im;
		logic [31:0] lo_re;    // dividend bits still to shift in
		logic [31:0] lo_im;
		logic [31:0] q_re;
		logic [31:0] q_im;
		logic [63:0] sq_x;     // radicand bit pairs still to shift in
		logic [33:0] sq_rem;
		logic [31:0] sq_root;
	} cau_cell_t;

	// Per-item side data that rides along with the cells.
	typedef struct packed {
		cau_op_t            op;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic               neg_re;
		logic               neg_im;
		logic               big_re;
		logic               big_im;
		logic signed [31:0] simple_re;
		logic signed [31:0] simple_im;
		logic               simple_ov;
		logic               flag;
	} cau_side_t;

	typedef struct packed {
		logic               ov;
		logic signed [31:0] val;
	} cau_sat_t;

	// Saturate a 33-bit signed sum to 32 bits.
	function automatic cau_sat_t sat33(input logic signed [32:0] s);
		cau_sat_t r;
		r.ov = s[32] ^ s[31];
		if (r.ov) begin
			r.val = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r.val = s[31:0];
		end
		return r;
	endfunction

	// Sign and magnitude to saturated 32-bit; big marks a magnitude of 2^32 or more.
	function automatic cau_sat_t sat_q(input logic neg, input logic big, input logic [31:0] q);
		cau_sat_t r;
		if (neg) begin
			r.ov  = big || (q > 32'h8000_0000);
			r.val = r.ov ? 32'sh8000_0000 : $signed(32'd0 - q);
		end else begin
			r.ov  = big || q[31];
			r.val = r.ov ? 32'sh7FFF_FFFF : $signed(q);
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/cau_stream_if.sv =====
// Valid/ready stream channel carrying one item of type T.
`timescale 1ns / 1ps

interface cau_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cau_cell.sv =====
// One cell of the chain: a quotient bit for both parts and one root bit.
`timescale 1ns / 1ps

module cau_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  cau_pkg::cau_cell_t   in_cell,
	input  cau_pkg::cau_side_t   in_side,
	output logic                 out_valid,
	output cau_pkg::cau_cell_t   out_cell,
	output cau_pkg::cau_side_t   out_side
);

	logic               valid_q;
	cau_pkg::cau_cell_t cell_q;
	cau_pkg::cau_side_t side_q;
	cau_pkg::cau_cell_t nxt;

	logic [64:0] t_re, t_im, d65;
	logic        ge_re, ge_im;
	logic [35:0] t_sq, trial;
	logic        ge_sq;

	always_comb begin
		d65   = {1'b0, in_cell.den};
		t_re  = {in_cell.rem_re, in_cell.lo_re[31]};
		t_im  = {in_cell.rem_im, in_cell.lo_im[31]};
		ge_re = t_re >= d65;
		ge_im = t_im >= d65;
		t_sq  = {in_cell.sq_rem, in_cell.sq_x[63:62]};
		trial = {2'b00, in_cell.sq_root, 2'b01};
		ge_sq = t_sq >= trial;

		nxt         = in_cell;
		nxt.rem_re  = ge_re ? 64'(t_re - d65) : t_re[63:0];
		nxt.rem_im  = ge_im ? 64'(t_im - d65) : t_im[63:0];
		nxt.lo_re   = {in_cell.lo_re[30:0], 1'b0};
		nxt.lo_im   = {in_cell.lo_im[30:0], 1'b0};
		nxt.q_re    = {in_cell.q_re[30:0], ge_re};
		nxt.q_im    = {in_cell.q_im[30:0], ge_im};
		nxt.sq_x    = {in_cell.sq_x[61:0], 2'b00};
		nxt.sq_rem  = ge_sq ? 34'(t_sq - trial) : t_sq[33:0];
		nxt.sq_root = {in_cell.sq_root[30:0], ge_sq};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_cell  = cell_q;
	assign out_side  = side_q;

endmodule

// ===== hw/rtl/cau_front.sv =====
// Front pipeline: products, sums, magnitudes and divider setup.
`timescale 1ns / 1ps

module cau_front #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  cau_pkg::cau_req_t  in_data,
	output logic               out_valid,
	output cau_pkg::cau_cell_t out_cell,
	output cau_pkg::cau_side_t out_side
);

	localparam int NW = 64 + FRAC_BITS;
	localparam int HW = 32 + FRAC_BITS;

	// stage 1: products
	logic               v_s1;
	cau_pkg::cau_op_t   op_s1;
	logic signed [31:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [63:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	cau_pkg::cau_op_t   op_c;
	logic signed [31:0] m4_c, m5_c;

	assign op_c = cau_pkg::cau_op_t'(in_data.opcode);
	assign m4_c = (op_c == cau_pkg::OP_MAG) ? in_data.a_real : in_data.b_real;
	assign m5_c = (op_c == cau_pkg::OP_MAG) ? in_data.a_imag : in_data.b_imag;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op_c;
			ar_s1 <= in_data.a_real;
			ai_s1 <= in_data.a_imag;
			br_s1 <= in_data.b_real;
			bi_s1 <= in_data.b_imag;
			p0_s1 <= in_data.a_real * in_data.b_real;
			p1_s1 <= in_data.a_imag * in_data.b_imag;
			p2_s1 <= in_data.a_real * in_data.b_imag;
			p3_s1 <= in_data.a_imag * in_data.b_real;
			p4_s1 <= m4_c * m4_c;
			p5_s1 <= m5_c * m5_c;
		end
	end

	// stage 2: sums and the simple operations
	logic               v_s2;
	cau_pkg::cau_side_t side_s2;
	logic signed [64:0] sum_re_s2, sum_im_s2;
	logic [63:0]        den_s2;
	cau_pkg::cau_side_t side2_c;
	cau_pkg::cau_sat_t  sr_c, si_c;

	always_comb begin
		side2_c      = '0;
		side2_c.op   = op_s1;
		side2_c.a_re = ar_s1;
		side2_c.a_im = ai_s1;
		sr_c         = '0;
		si_c         = '0;
		unique case (op_s1)
			cau_pkg::OP_ADD: begin
				sr_c = cau_pkg::sat33(33'(ar_s1) + 33'(br_s1));
				si_c = cau_pkg::sat33(33'(ai_s1) + 33'(bi_s1));
			end
			cau_pkg::OP_SUB: begin
				sr_c = cau_pkg::sat33(33'(ar_s1) - 33'(br_s1));
				si_c = cau_pkg::sat33(33'(ai_s1) - 33'(bi_s1));
			end
			cau_pkg::OP_NEG: begin
				sr_c = cau_pkg::sat33(33'sd0 - 33'(ar_s1));
				si_c = cau_pkg::sat33(33'sd0 - 33'(ai_s1));
			end
			cau_pkg::OP_CONJ: begin
				sr_c.val = ar_s1;
				si_c = cau_pkg::sat33(33'sd0 - 33'(ai_s1));
			end
			cau_pkg::OP_EQ: begin
				side2_c.flag = (ar_s1 == br_s1) && (ai_s1 == bi_s1);
			end
			cau_pkg::OP_DIV: begin
				side2_c.flag = (br_s1 == 32'sd0) && (bi_s1 == 32'sd0);
			end
			cau_pkg::OP_MUL, cau_pkg::OP_MAG: begin
			end
		endcase
		side2_c.simple_re = sr_c.val;
		side2_c.simple_im = si_c.val;
		side2_c.simple_ov = sr_c.ov | si_c.ov;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2   <= side2_c;
			sum_re_s2 <= (op_s1 == cau_pkg::OP_DIV) ? 65'(p0_s1) + 65'(p1_s1)
			                                        : 65'(p0_s1) - 65'(p1_s1);
			sum_im_s2 <= (op_s1 == cau_pkg::OP_DIV) ? 65'(p3_s1) - 65'(p2_s1)
			                                        : 65'(p2_s1) + 65'(p3_s1);
			den_s2    <= $unsigned(p4_s1) + $unsigned(p5_s1);
		end
	end

	// stage 3: sign and magnitude
	logic               v_s3;
	cau_pkg::cau_side_t side_s3;
	logic [63:0]        mag_re_s3, mag_im_s3, den_s3;
	logic signed [64:0] nre_c, nim_c;
	cau_pkg::cau_side_t side3_c;

	assign nre_c = 65'sd0 - sum_re_s2;
	assign nim_c = 65'sd0 - sum_im_s2;

	always_comb begin
		side3_c        = side_s2;
		side3_c.neg_re = sum_re_s2[64];
		side3_c.neg_im = sum_im_s2[64];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3   <= side3_c;
			mag_re_s3 <= sum_re_s2[64] ? nre_c[63:0] : sum_re_s2[63:0];
			mag_im_s3 <= sum_im_s2[64] ? nim_c[63:0] : sum_im_s2[63:0];
			den_s3    <= den_s2;
		end
	end

	// stage 4: product scaling and divider setup
	logic               v_s4;
	cau_pkg::cau_side_t side_s4;
	cau_pkg::cau_cell_t cell_s4;
	cau_pkg::cau_side_t side4_c;
	cau_pkg::cau_cell_t cell4_c;
	logic [63:0]        shr_re, shr_im;
	logic [NW-1:0]      n_re, n_im;
	logic [HW-1:0]      hi_re, hi_im;
	cau_pkg::cau_sat_t  mr_c, mi_c;

	always_comb begin
		shr_re = mag_re_s3 >> FRAC_BITS;
		shr_im = mag_im_s3 >> FRAC_BITS;
		mr_c   = cau_pkg::sat_q(side_s3.neg_re, |shr_re[63:32], shr_re[31:0]);
		mi_c   = cau_pkg::sat_q(side_s3.neg_im, |shr_im[63:32], shr_im[31:0]);
		n_re   = NW'(mag_re_s3) << FRAC_BITS;
		n_im   = NW'(mag_im_s3) << FRAC_BITS;
		hi_re  = n_re[NW-1:32];
		hi_im  = n_im[NW-1:32];

		side4_c        = side_s3;
		side4_c.big_re = 64'(hi_re) >= den_s3;
		side4_c.big_im = 64'(hi_im) >= den_s3;
		if (side_s3.op == cau_pkg::OP_MUL) begin
			side4_c.simple_re = mr_c.val;
			side4_c.simple_im = mi_c.val;
			side4_c.simple_ov = mr_c.ov | mi_c.ov;
		end

		cell4_c        = '0;
		cell4_c.den    = den_s3;
		cell4_c.rem_re = 64'(hi_re);
		cell4_c.rem_im = 64'(hi_im);
		cell4_c.lo_re  = n_re[31:0];
		cell4_c.lo_im  = n_im[31:0];
		cell4_c.sq_x   = den_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side4_c;
			cell_s4 <= cell4_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_cell  = cell_s4;
	assign out_side  = side_s4;

endmodule

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: front pipeline, cell chain, output register.
`timescale 1ns / 1ps
// Structure: 4 front stages, 32 cells and the output register lie between an accepted item and its result.
// Throughput: one item per cycle unless stalled; every operation runs through the same pipeline, and the
//   32-cell chain (one quotient/root bit per cell) sets the depth.
// A waiting result only stalls the pipeline once the last cell holds a further item.
// Reset (arst_n low) clears the valid bits of all stages; data registers are not reset.

module complex_arithmetic_unit #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	cau_stream_if.sink   req,
	cau_stream_if.source rsp
);

	localparam int N = cau_pkg::NCELLS;

	logic               en;
	logic               stall;
	logic               v_c [0:N];
	cau_pkg::cau_cell_t c_c [0:N];
	cau_pkg::cau_side_t s_c [0:N];

	logic              out_valid_q;
	cau_pkg::cau_rsp_t res_q;
	cau_pkg::cau_rsp_t res_c;

	// Hold everything only when the output is occupied and not taken, and the last cell has an item to hand over.
	assign stall   = out_valid_q && !rsp.ready && v_c[N];
	assign en      = !stall;
	assign req.ready = en;

	cau_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (req.valid),
		.in_data  (req.data),
		.out_valid(v_c[0]),
		.out_cell (c_c[0]),
		.out_side (s_c[0])
	);

	// Cell chain: each cell resolves one quotient bit of both parts and one root bit.
	for (genvar g = 0; g < N; g++) begin : g_cell
		cau_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v_c[g]),
			.in_cell  (c_c[g]),
			.in_side  (s_c[g]),
			.out_valid(v_c[g+1]),
			.out_cell (c_c[g+1]),
			.out_side (s_c[g+1])
		);
	end

	// Final select and saturation.
	cau_pkg::cau_sat_t qr_c, qi_c, rt_c;

	always_comb begin
		qr_c = cau_pkg::sat_q(s_c[N].neg_re, s_c[N].big_re, c_c[N].q_re);
		qi_c = cau_pkg::sat_q(s_c[N].neg_im, s_c[N].big_im, c_c[N].q_im);
		rt_c = cau_pkg::sat_q(1'b0, 1'b0, c_c[N].sq_root);
		res_c.res_real = s_c[N].simple_re;
		res_c.res_imag = s_c[N].simple_im;
		res_c.flag     = s_c[N].flag;
		res_c.overflow = s_c[N].simple_ov;
		unique case (s_c[N].op)
			cau_pkg::OP_DIV: begin
				if (s_c[N].flag) begin
					// divide by zero: pass the dividend through
					res_c.res_real = s_c[N].a_re;
					res_c.res_imag = s_c[N].a_im;
					res_c.overflow = 1'b0;
				end else begin
					res_c.res_real = qr_c.val;
					res_c.res_imag = qi_c.val;
					res_c.overflow = qr_c.ov | qi_c.ov;
				end
			end
			cau_pkg::OP_MAG: begin
				res_c.res_real = rt_c.val;
				res_c.res_imag = 32'sd0;
				res_c.flag     = 1'b0;
				res_c.overflow = rt_c.ov;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!stall) begin
			if (v_c[N]) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && v_c[N]) begin
			res_q <= res_c;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = res_q;

	// A pending result with another item behind it must block new input.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready && v_c[N]) |-> !req.ready)
		else $error("input taken while output is blocked");

	// An item leaving the chain always lands in the output register.
	a_land: assert property (@(posedge clk) disable iff (!arst_n)
		(v_c[N] && en) |=> rsp.valid)
		else $error("item lost at the output");

	// Flag only comes from divide by zero or a match, neither of which saturates.
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.data.flag && rsp.data.overflow))
		else $error("flag and overflow both set");

endmodule

// ===== tb/tb_complex_arithmetic_unit.sv =====
// Testbench for the complex arithmetic unit: random and directed items, scoreboard check.
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit;
	import cau_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	// Drain time after the last expected result has arrived.
	localparam int DRAIN_CYCLES = 60;
	localparam int N_RANDOM = 1500;
	// Slowest correct run: every item at the longest idle draw on each side plus the pipeline.
	localparam int CYCLE_LIMIT = 400000;

	// Expected results of accepted items, oldest first, and the arithmetic behind them.
	class cau_scoreboard;
		cau_rsp_t pending[$];
		int       n_errors = 0;

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			n_errors++;
		endtask

		// Saturate an exact signed value to 32 bits.
		function logic signed [31:0] clamp(logic signed [65:0] v, inout logic ov);
			if (v > 66'sh7FFF_FFFF) begin
				ov = 1'b1;
				return 32'sh7FFF_FFFF;
			end
			if (v < -66'sh8000_0000) begin
				ov = 1'b1;
				return 32'sh8000_0000;
			end
			return v[31:0];
		endfunction

		// Sign and magnitude to a saturated 32-bit part.
		function logic signed [31:0] clamp_mag(logic neg, logic [127:0] m, inout logic ov);
			if (neg) begin
				if (m > 128'h8000_0000) begin
					ov = 1'b1;
					return 32'sh8000_0000;
				end
				return 32'd0 - m[31:0];
			end
			if (m > 128'h7FFF_FFFF) begin
				ov = 1'b1;
				return 32'sh7FFF_FFFF;
			end
			return m[31:0];
		endfunction

		function logic [127:0] abs_val(logic signed [65:0] v);
			logic [127:0] m;
			m = (v < 0) ? 128'(-v) : 128'(v);
			return m;
		endfunction

		// Floor of the square root.
		function logic [63:0] floor_sqrt(logic [63:0] x);
			logic [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function cau_rsp_t compute(cau_req_t q);
			cau_rsp_t o;
			logic signed [65:0] ar, ai, br, bi, s, den;
			logic [127:0] m;
			logic ov;
			ar = q.a_real;
			ai = q.a_imag;
			br = q.b_real;
			bi = q.b_imag;
			ov = 1'b0;
			o = '0;
			case (cau_op_t'(q.opcode))
				OP_ADD: begin
					o.res_real = clamp(ar + br, ov);
					o.res_imag = clamp(ai + bi, ov);
				end
				OP_SUB: begin
					o.res_real = clamp(ar - br, ov);
					o.res_imag = clamp(ai - bi, ov);
				end
				OP_MUL: begin
					s = ar * br - ai * bi;
					o.res_real = clamp_mag(s < 0, abs_val(s) >> FRAC, ov);
					s = ar * bi + ai * br;
					o.res_imag = clamp_mag(s < 0, abs_val(s) >> FRAC, ov);
				end
				OP_DIV: begin
					if (br == 0 && bi == 0) begin
						// zero divisor: dividend passes through, flag raised
						o.res_real = q.a_real;
						o.res_imag = q.a_imag;
						o.flag = 1'b1;
					end else begin
						den = br * br + bi * bi;
						s = ar * br + ai * bi;
						m = (abs_val(s) << FRAC) / 128'(den);
						o.res_real = clamp_mag(s < 0, m, ov);
						s = ai * br - ar * bi;
						m = (abs_val(s) << FRAC) / 128'(den);
						o.res_imag = clamp_mag(s < 0, m, ov);
					end
				end
				OP_NEG: begin
					o.res_real = clamp(-ar, ov);
					o.res_imag = clamp(-ai, ov);
				end
				OP_CONJ: begin
					o.res_real = q.a_real;
					o.res_imag = clamp(-ai, ov);
				end
				OP_MAG: begin
					s = ar * ar + ai * ai;
					o.res_real = clamp_mag(1'b0, 128'(floor_sqrt(s[63:0])), ov);
				end
				default: begin
					o.flag = (ar == br) && (ai == bi);
				end
			endcase
			o.overflow = ov;
			return o;
		endfunction

		function void note_request(cau_req_t q);
			pending.push_back(compute(q));
		endfunction

		task check_result(cau_rsp_t got);
			cau_rsp_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %h", got));
				return;
			end
			want = pending.pop_front();
			if (got.res_real !== want.res_real)
				report($sformatf("res_real %h, expected %h", got.res_real, want.res_real));
			if (got.res_imag !== want.res_imag)
				report($sformatf("res_imag %h, expected %h", got.res_imag, want.res_imag));
			if (got.flag !== want.flag)
				report($sformatf("flag %b, expected %b", got.flag, want.flag));
			if (got.overflow !== want.overflow)
				report($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic no_idle;       // both sides skip their idle cycles while set
	int   cycles;

	cau_stream_if #(.T(cau_req_t)) req_ch ();
	cau_stream_if #(.T(cau_rsp_t)) rsp_ch ();

	cau_scoreboard sb = new();

	complex_arithmetic_unit #(.FRAC_BITS(FRAC)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Hard stop on a hang.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	function automatic int idle_draw();
		return no_idle ? 0 : $urandom_range(0, 8);
	endfunction

	// One item: idle for a drawn number of cycles, then hold it until accepted.
	// Entered and left just after a falling edge, so valid gets one update per step.
	task automatic send_item(cau_req_t q);
		int gap;
		gap = idle_draw();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= q;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.note_request(q);
		@(negedge clk);
	endtask

	task automatic send_fields(cau_op_t op, logic [31:0] ar, logic [31:0] ai,
			logic [31:0] br, logic [31:0] bi);
		cau_req_t q;
		q.opcode = op;
		q.a_real = ar;
		q.a_imag = ai;
		q.b_real = br;
		q.b_imag = bi;
		send_item(q);
	endtask

	// Hold back until every outstanding result has come.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	// Operand mix: full range, small Q values, near-unity values and corner values.
	function automatic logic [31:0] pick_operand();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = $urandom;
			2: v = 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
			3: v = 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
			4: v = 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
			default: begin
				case ($urandom_range(0, 6))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'h0000_0000;
					3: v = 32'h0001_0000;
					4: v = 32'hFFFF_0000;
					5: v = 32'h0000_0001;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
		endcase
		return v;
	endfunction

	initial begin
		cau_req_t q;
		arst_n        = 1'b0;
		cycles        = 0;
		no_idle       = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.data   = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: every operation and a set of corner values.
		send_fields(OP_ADD,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
		send_fields(OP_ADD,  32'h0001_8000, 32'hFFFE_0000, 32'h0000_8000, 32'h0001_0000);
		send_fields(OP_SUB,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
		send_fields(OP_SUB,  32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 32'h0002_0000);
		send_fields(OP_MUL,  32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000);
		send_fields(OP_MUL,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_fields(OP_MUL,  32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
		send_fields(OP_DIV,  32'h0005_0000, 32'hFFFD_0000, 32'h0000_0000, 32'h0000_0000);
		send_fields(OP_DIV,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
		send_fields(OP_DIV,  32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
		send_fields(OP_DIV,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
		send_fields(OP_DIV,  32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
		send_fields(OP_DIV,  32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);
		send_fields(OP_NEG,  32'h8000_0000, 32'h0001_0000, 32'h0, 32'h0);
		send_fields(OP_NEG,  32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_fields(OP_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
		send_fields(OP_CONJ, 32'h0001_2345, 32'hFFFE_0000, 32'h0, 32'h0);
		send_fields(OP_MAG,  32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
		send_fields(OP_MAG,  32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
		send_fields(OP_MAG,  32'h7FFF_FFFF, 32'h0000_0000, 32'h0, 32'h0);
		send_fields(OP_EQ,   32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000);
		send_fields(OP_EQ,   32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0001);
		send_fields(OP_EQ,   32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFE, 32'h0);

		// Pipeline fully drained before the random part.
		wait_drained();

		for (int i = 0; i < N_RANDOM; i++) begin
			// Alternate stretches with and without idle cycles.
			if (i % 100 == 0) no_idle <= ($urandom_range(0, 3) == 0);
			if (i == N_RANDOM / 2) wait_drained();
			q.opcode = 3'($urandom_range(0, 7));
			q.a_real = pick_operand();
			q.a_imag = pick_operand();
			q.b_real = pick_operand();
			q.b_imag = pick_operand();
			if (cau_op_t'(q.opcode) == OP_DIV && $urandom_range(0, 5) == 0) begin
				q.b_real = '0;
				q.b_imag = '0;
			end
			if (cau_op_t'(q.opcode) == OP_EQ && $urandom_range(0, 1) == 0) begin
				q.b_real = q.a_real;
				q.b_imag = ($urandom_range(0, 2) == 0) ? q.a_imag ^ (32'd1 << $urandom_range(0, 31))
					: q.a_imag;
			end
			send_item(q);
		end
		req_ch.valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.n_errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Result side: draws its own stall per item, samples on the rising edge.
	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = idle_draw();
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			sb.check_result(rsp_ch.data);
			@(negedge clk);
		end
	end

endmodule

// ===== files.f =====
hw/rtl/cau_pkg.sv
hw/rtl/cau_stream_if.sv
hw/rtl/cau_cell.sv
hw/rtl/cau_front.sv
hw/rtl/complex_arithmetic_unit.sv
tb/tb_complex_arithmetic_unit.sv
